// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== hw/rtl/ncpu_pkg.sv =====
// ----------------------------------------------------------------------------
// ncpu_pkg
// Types, opcode codes and sizing constants of the nibble CPU step core.
// ----------------------------------------------------------------------------
package ncpu_pkg;

	localparam int STACK_LEVELS = 3;
	localparam int SP_W         = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;

	// JCN condition select bits
	localparam logic [3:0] JCN_INVERT   = 4'b1000;
	localparam logic [3:0] JCN_ACC_ZERO = 4'b0100;
	localparam logic [3:0] JCN_CARRY    = 4'b0010;
	localparam logic [3:0] JCN_TEST_LOW = 4'b0001;

	// Opcode groups (high nibble of the first byte)
	typedef enum logic [3:0] {
		GRP_NOP     = 4'h0,
		GRP_JCN     = 4'h1,
		GRP_FIM_SRC = 4'h2,
		GRP_FIN_JIN = 4'h3,
		GRP_JUN     = 4'h4,
		GRP_JMS     = 4'h5,
		GRP_INC     = 4'h6,
		GRP_ISZ     = 4'h7,
		GRP_ADD     = 4'h8,
		GRP_SUB     = 4'h9,
		GRP_LD      = 4'hA,
		GRP_XCH     = 4'hB,
		GRP_BBL     = 4'hC,
		GRP_LDM     = 4'hD,
		GRP_IO      = 4'hE,
		GRP_ACC     = 4'hF
	} grp_t;

	// Accumulator group operations (low nibble under GRP_ACC)
	typedef enum logic [3:0] {
		ACC_CLB = 4'h0,
		ACC_CLC = 4'h1,
		ACC_IAC = 4'h2,
		ACC_CMC = 4'h3,
		ACC_CMA = 4'h4,
		ACC_RAL = 4'h5,
		ACC_RAR = 4'h6,
		ACC_TCC = 4'h7,
		ACC_DAC = 4'h8,
		ACC_TCS = 4'h9,
		ACC_STC = 4'hA,
		ACC_DAA = 4'hB,
		ACC_KBP = 4'hC,
		ACC_DCL = 4'hD
	} acc_op_t;

	typedef struct packed {
		logic [7:0] instr_byte;
		logic [7:0] second_byte;
		logic       test_pin;
		logic [7:0] fin_data;
	} ncpu_item_t;

	typedef struct packed {
		logic [3:0]  acc_out;
		logic        carry_out;
		logic [11:0] pc_out;
		logic [1:0]  instr_cycles;
		logic        src_valid;
		logic [7:0]  src_address;
		logic [7:0]  pair_zero_value;
	} ncpu_res_t;

	// Architectural state as seen by the execute logic
	typedef struct packed {
		logic [3:0]  acc;
		logic        carry;
		logic [11:0] pc;
		logic [7:0]  pair_rd;
		logic [7:0]  pair0;
		logic [11:0] ret_addr;
	} ncpu_view_t;

	// State update produced by the execute logic
	typedef struct packed {
		logic [3:0]  acc;
		logic        carry;
		logic [11:0] pc;
		logic        pair_we;
		logic [7:0]  pair_wdata;
		logic        push;
		logic        pop;
		logic [11:0] push_addr;
	} ncpu_upd_t;

endpackage

// ===== hw/rtl/ncpu_if.sv =====
// ----------------------------------------------------------------------------
// ncpu_if
// Valid/ready channels carrying instruction items and result items.
// ----------------------------------------------------------------------------
interface ncpu_in_if;
	import ncpu_pkg::*;

	logic       valid;
	logic       ready;
	ncpu_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ncpu_out_if;
	import ncpu_pkg::*;

	logic      valid;
	logic      ready;
	ncpu_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ncpu_state.sv =====
// ----------------------------------------------------------------------------
// ncpu_state
// Architectural registers: index register pairs, accumulator, carry, program
// counter and the wrapping return stack.
// ----------------------------------------------------------------------------
module ncpu_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  logic [2:0]           pair_sel,
	input  ncpu_pkg::ncpu_upd_t  upd,
	output ncpu_pkg::ncpu_view_t view
);
	import ncpu_pkg::*;

	logic [7:0]      pairs_q [8];
	logic [11:0]     stack_q [STACK_LEVELS];
	logic [SP_W-1:0] sp_q;
	logic [3:0]      acc_q;
	logic            carry_q;
	logic [11:0]     pc_q;
	logic [SP_W-1:0] sp_prev;
	logic [SP_W-1:0] sp_succ;

	always_comb begin
		sp_prev = (sp_q == '0) ? SP_W'(STACK_LEVELS - 1) : sp_q - 1'b1;
		sp_succ = (sp_q == SP_W'(STACK_LEVELS - 1)) ? '0 : sp_q + 1'b1;
	end

	always_comb begin
		view.acc      = acc_q;
		view.carry    = carry_q;
		view.pc       = pc_q;
		view.pair_rd  = pairs_q[pair_sel];
		view.pair0    = pairs_q[0];
		view.ret_addr = stack_q[sp_prev];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			carry_q <= 1'b0;
			pc_q    <= '0;
			sp_q    <= '0;
			for (int i = 0; i < 8; i++) pairs_q[i] <= '0;
			for (int i = 0; i < STACK_LEVELS; i++) stack_q[i] <= '0;
		end else if (commit) begin
			acc_q   <= upd.acc;
			carry_q <= upd.carry;
			pc_q    <= upd.pc;
			if (upd.pair_we) pairs_q[pair_sel] <= upd.pair_wdata;
			if (upd.push) begin
				stack_q[sp_q] <= upd.push_addr;
				sp_q          <= sp_succ;
			end else if (upd.pop) begin
				sp_q <= sp_prev;
			end
		end
	end

endmodule

// ===== hw/rtl/ncpu_exec.sv =====
// ----------------------------------------------------------------------------
// ncpu_exec
// Decode and execute of one instruction: next state and the result item.
// ----------------------------------------------------------------------------
module ncpu_exec (
	input  ncpu_pkg::ncpu_item_t item,
	input  ncpu_pkg::ncpu_view_t view,
	output ncpu_pkg::ncpu_upd_t  upd,
	output ncpu_pkg::ncpu_res_t  res
);
	import ncpu_pkg::*;

	grp_t        grp;
	logic [3:0]  opa;
	logic        two;
	logic [11:0] pc_adv;
	logic [3:0]  sel_reg;
	logic [3:0]  reg_inc;
	logic [4:0]  sum;
	logic        jump;

	// Replace the addressed nibble of the selected pair
	function automatic logic [7:0] merge(logic [7:0] pair, logic odd, logic [3:0] v);
		logic [7:0] r;
		r = odd ? {pair[7:4], v} : {v, pair[3:0]};
		return r;
	endfunction

	always_comb begin
		grp     = grp_t'(item.instr_byte[7:4]);
		opa     = item.instr_byte[3:0];
		two     = (grp == GRP_JCN) || (grp == GRP_JUN) || (grp == GRP_JMS) ||
			(grp == GRP_ISZ) || ((grp == GRP_FIM_SRC) && !opa[0]);
		pc_adv  = view.pc + (two ? 12'd2 : 12'd1);
		sel_reg = opa[0] ? view.pair_rd[3:0] : view.pair_rd[7:4];
		reg_inc = sel_reg + 4'd1;
		sum     = '0;
		jump    = 1'b0;

		upd.acc        = view.acc;
		upd.carry      = view.carry;
		upd.pc         = pc_adv;
		upd.pair_we    = 1'b0;
		upd.pair_wdata = view.pair_rd;
		upd.push       = 1'b0;
		upd.pop        = 1'b0;
		upd.push_addr  = pc_adv;

		res.instr_cycles = two ? 2'd2 : 2'd1;
		res.src_valid    = 1'b0;
		res.src_address  = '0;

		case (grp)
			GRP_JCN: begin
				jump = (((opa & JCN_ACC_ZERO) != '0) && (view.acc == '0)) ||
					(((opa & JCN_CARRY) != '0) && view.carry) ||
					(((opa & JCN_TEST_LOW) != '0) && !item.test_pin);
				if ((opa & JCN_INVERT) != '0) jump = !jump;
				if (jump) upd.pc = {pc_adv[11:8], item.second_byte};
			end
			GRP_FIM_SRC: begin
				if (opa[0]) begin
					res.src_valid   = 1'b1;
					res.src_address = view.pair_rd;
				end else begin
					upd.pair_we    = 1'b1;
					upd.pair_wdata = item.second_byte;
				end
			end
			GRP_FIN_JIN: begin
				if (opa[0]) begin
					upd.pc = {pc_adv[11:8], view.pair_rd};
				end else begin
					upd.pair_we      = 1'b1;
					upd.pair_wdata   = item.fin_data;
					res.instr_cycles = 2'd2;
				end
			end
			GRP_JUN: begin
				upd.pc = {opa, item.second_byte};
			end
			GRP_JMS: begin
				upd.push = 1'b1;
				upd.pc   = {opa, item.second_byte};
			end
			GRP_INC: begin
				upd.pair_we    = 1'b1;
				upd.pair_wdata = merge(view.pair_rd, opa[0], reg_inc);
			end
			GRP_ISZ: begin
				upd.pair_we    = 1'b1;
				upd.pair_wdata = merge(view.pair_rd, opa[0], reg_inc);
				if (reg_inc != '0) upd.pc = {pc_adv[11:8], item.second_byte};
			end
			GRP_ADD: begin
				sum       = {1'b0, view.acc} + {1'b0, sel_reg} + {4'd0, view.carry};
				upd.acc   = sum[3:0];
				upd.carry = sum[4];
			end
			GRP_SUB: begin
				// add the complement; carry set means no borrow
				sum       = {1'b0, view.acc} + {1'b0, ~sel_reg} + {4'd0, ~view.carry};
				upd.acc   = sum[3:0];
				upd.carry = sum[4];
			end
			GRP_LD: begin
				upd.acc = sel_reg;
			end
			GRP_XCH: begin
				upd.acc        = sel_reg;
				upd.pair_we    = 1'b1;
				upd.pair_wdata = merge(view.pair_rd, opa[0], view.acc);
			end
			GRP_BBL: begin
				upd.acc = opa;
				upd.pop = 1'b1;
				upd.pc  = view.ret_addr;
			end
			GRP_LDM: begin
				upd.acc = opa;
			end
			GRP_ACC: begin
				case (acc_op_t'(opa))
					ACC_CLB: begin
						upd.acc   = '0;
						upd.carry = 1'b0;
					end
					ACC_CLC: upd.carry = 1'b0;
					ACC_IAC: begin
						sum       = {1'b0, view.acc} + 5'd1;
						upd.acc   = sum[3:0];
						upd.carry = sum[4];
					end
					ACC_CMC: upd.carry = ~view.carry;
					ACC_CMA: upd.acc = ~view.acc;
					ACC_RAL: begin
						upd.acc   = {view.acc[2:0], view.carry};
						upd.carry = view.acc[3];
					end
					ACC_RAR: begin
						upd.acc   = {view.carry, view.acc[3:1]};
						upd.carry = view.acc[0];
					end
					ACC_DAC: begin
						sum       = {1'b0, view.acc} + 5'd15;
						upd.acc   = sum[3:0];
						upd.carry = sum[4];
					end
					ACC_STC: upd.carry = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase

		res.acc_out         = upd.acc;
		res.carry_out       = upd.carry;
		res.pc_out          = upd.pc;
		res.pair_zero_value = (upd.pair_we && (opa[3:1] == 3'd0)) ? upd.pair_wdata
			: view.pair0;
	end

endmodule

// ===== hw/rtl/nibble_cpu_instruction_step.sv =====
// ----------------------------------------------------------------------------
// nibble_cpu_instruction_step
// 4-bit CPU core executing one instruction per transaction.
// ----------------------------------------------------------------------------
// An accepted instruction lands in an input register and executes once the
// output register is free or draining, against the register file, accumulator,
// carry, PC and return stack, which are all updated as it executes; its result
// is then held in an output register until taken. Throughput is one instruction
// per clock while the result side does not stall. A result passes the input
// register, then the output register. Execute reads the architectural state
// combinationally and writes it as it commits, so each instruction sees
// everything the previous one left. Reset clears the state and valid flags.
module nibble_cpu_instruction_step (
	input logic        clk,
	input logic        arst_n,
	ncpu_in_if.sink    in_ch,
	ncpu_out_if.source out_ch
);
	import ncpu_pkg::*;

	ncpu_item_t item_s1;
	logic       valid_s1;
	ncpu_res_t  res_q;
	logic       out_valid_q;
	logic       advance;
	logic       accept;
	ncpu_view_t view;
	ncpu_upd_t  upd;
	ncpu_res_t  res;

	// execute when the output register is free or being drained
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign accept       = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= in_ch.data;
		if (advance) res_q <= res;
	end

	ncpu_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (advance),
		.pair_sel (item_s1.instr_byte[3:1]),
		.upd      (upd),
		.view     (view)
	);

	ncpu_exec u_exec (
		.item (item_s1),
		.view (view),
		.upd  (upd),
		.res  (res)
	);

endmodule

// ===== hw/rtl/ncpu_checker.sv =====
// ----------------------------------------------------------------------------
// ncpu_checker
// Port-level checks of the step core's flow control, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ncpu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input ncpu_pkg::ncpu_res_t out_data
);
	import ncpu_pkg::*;

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// a stalled result keeps its payload
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))

	// input backs up only behind a stalled result
	`ASSERT_IMPL(a_ready_low, clk, arst_n, !in_ready, out_valid && !out_ready)

	// a new result follows an accepted transaction through the input and output registers
	`ASSERT_IMPL(a_out_source, clk, arst_n, $rose(out_valid),
		$past(in_valid && in_ready, 2))

endmodule

bind nibble_cpu_instruction_step ncpu_checker u_ncpu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

// ===== bench/nibble_cpu_instruction_step_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_cpu_instruction_step_tb
// Self-checking bench for the 4-bit CPU instruction step core. A driver feeds
// instructions in random bursts while the result side stalls on its own
// pattern. Every accepted instruction runs through an in-bench model of the
// core, and each result transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module nibble_cpu_instruction_step_tb;
	import ncpu_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;

	ncpu_in_if  in_ch ();
	ncpu_out_if out_ch ();

	nibble_cpu_instruction_step uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Architectural state of the model core
	logic [3:0]  gpr_file [16];
	logic [3:0]  cpu_acc;
	logic        cpu_carry;
	logic [11:0] cpu_pc;
	logic [11:0] ret_stack [STACK_LEVELS];
	int          ret_sp;

	ncpu_item_t pending_instrs [$];
	ncpu_res_t  expected_states [$];

	int total_items;
	int items_accepted;
	int results_checked;
	int mismatch_count;
	int cycle_count;
	int group_hits [16];

	int  burst_left;
	int  gap_left;
	int  stall_mode;
	int  mode_left;
	int  hold_left;
	bit  hold_done;

	function automatic logic [7:0] pair_read(input logic [2:0] p);
		return {gpr_file[{p, 1'b0}], gpr_file[{p, 1'b1}]};
	endfunction

	task automatic pair_write(input logic [2:0] p, input logic [7:0] v);
		gpr_file[{p, 1'b0}] = v[7:4];
		gpr_file[{p, 1'b1}] = v[3:0];
	endtask

	// Run one instruction on the model and queue the state it leaves behind
	task automatic execute_instruction(input ncpu_item_t it);
		grp_t        grp;
		acc_op_t     aop;
		logic [3:0]  opa;
		logic        two_word;
		logic        jump;
		logic [4:0]  sum;
		logic [3:0]  tmp;
		ncpu_res_t   res;

		grp = grp_t'(it.instr_byte[7:4]);
		opa = it.instr_byte[3:0];
		aop = acc_op_t'(opa);
		res = '0;
		two_word = (grp == GRP_JCN) || (grp == GRP_JUN) || (grp == GRP_JMS) ||
			(grp == GRP_ISZ) || (grp == GRP_FIM_SRC && !opa[0]);
		res.instr_cycles = two_word ? 2'd2 : 2'd1;
		cpu_pc = cpu_pc + (two_word ? 12'd2 : 12'd1);
		group_hits[it.instr_byte[7:4]]++;

		case (grp)
			GRP_JCN: begin
				jump = 1'b0;
				if ((opa & JCN_ACC_ZERO) != 0 && cpu_acc == 4'd0)
					jump = 1'b1;
				if ((opa & JCN_CARRY) != 0 && cpu_carry)
					jump = 1'b1;
				if ((opa & JCN_TEST_LOW) != 0 && !it.test_pin)
					jump = 1'b1;
				if ((opa & JCN_INVERT) != 0)
					jump = !jump;
				if (jump)
					cpu_pc[7:0] = it.second_byte;
			end
			GRP_FIM_SRC: begin
				if (opa[0]) begin
					res.src_valid   = 1'b1;
					res.src_address = pair_read(opa[3:1]);
				end else begin
					pair_write(opa[3:1], it.second_byte);
				end
			end
			GRP_FIN_JIN: begin
				if (opa[0]) begin
					cpu_pc[7:0] = pair_read(opa[3:1]);
				end else begin
					pair_write(opa[3:1], it.fin_data);
					res.instr_cycles = 2'd2;
				end
			end
			GRP_JUN: cpu_pc = {opa, it.second_byte};
			GRP_JMS: begin
				ret_stack[ret_sp] = cpu_pc;
				ret_sp = (ret_sp + 1) % STACK_LEVELS;
				cpu_pc = {opa, it.second_byte};
			end
			GRP_INC: gpr_file[opa] = gpr_file[opa] + 4'd1;
			GRP_ISZ: begin
				gpr_file[opa] = gpr_file[opa] + 4'd1;
				if (gpr_file[opa] != 4'd0)
					cpu_pc[7:0] = it.second_byte;
			end
			GRP_ADD: begin
				sum = {1'b0, cpu_acc} + {1'b0, gpr_file[opa]} + {4'd0, cpu_carry};
				{cpu_carry, cpu_acc} = sum;
			end
			GRP_SUB: begin
				// complement at nibble width; carry set means no borrow
				sum = {1'b0, cpu_acc} + {1'b0, ~gpr_file[opa]} + {4'd0, ~cpu_carry};
				{cpu_carry, cpu_acc} = sum;
			end
			GRP_LD: cpu_acc = gpr_file[opa];
			GRP_XCH: begin
				tmp = cpu_acc;
				cpu_acc = gpr_file[opa];
				gpr_file[opa] = tmp;
			end
			GRP_BBL: begin
				cpu_acc = opa;
				ret_sp = (ret_sp + STACK_LEVELS - 1) % STACK_LEVELS;
				cpu_pc = ret_stack[ret_sp];
			end
			GRP_LDM: cpu_acc = opa;
			GRP_ACC: begin
				case (aop)
					ACC_CLB: begin
						cpu_acc   = 4'd0;
						cpu_carry = 1'b0;
					end
					ACC_CLC: cpu_carry = 1'b0;
					ACC_IAC: begin
						sum = {1'b0, cpu_acc} + 5'd1;
						{cpu_carry, cpu_acc} = sum;
					end
					ACC_CMC: cpu_carry = !cpu_carry;
					ACC_CMA: cpu_acc = ~cpu_acc;
					ACC_RAL: {cpu_carry, cpu_acc} = {cpu_acc, cpu_carry};
					ACC_RAR: {cpu_acc, cpu_carry} = {cpu_carry, cpu_acc};
					ACC_DAC: begin
						sum = {1'b0, cpu_acc} + 5'd15;
						{cpu_carry, cpu_acc} = sum;
					end
					ACC_STC: cpu_carry = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase

		res.acc_out         = cpu_acc;
		res.carry_out       = cpu_carry;
		res.pc_out          = cpu_pc;
		res.pair_zero_value = pair_read(3'd0);
		expected_states.push_back(res);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
			$realtime, what, got, want, results_checked);
		mismatch_count++;
	endtask

	task automatic queue_instr(input logic [7:0] ib, input logic [7:0] b2,
		input logic tp, input logic [7:0] fd);
		ncpu_item_t it;

		it.instr_byte  = ib;
		it.second_byte = b2;
		it.test_pin    = tp;
		it.fin_data    = fd;
		pending_instrs.push_back(it);
	endtask

	// Instruction with random second byte, test pin and ROM byte
	task automatic queue_op(input grp_t g, input logic [3:0] opa);
		queue_instr({g, opa}, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Driver: offer pending instructions in bursts separated by idle gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				execute_instruction(in_ch.data);
				items_accepted++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
				if (burst_left > 0) begin
					if (pending_instrs.size() != 0) begin
						in_ch.valid <= 1'b1;
						in_ch.data  <= pending_instrs.pop_front();
					end else begin
						in_ch.valid <= 1'b0;
					end
					burst_left--;
				end else begin
					in_ch.valid <= 1'b0;
					gap_left--;
				end
			end
		end
	end

	// Receiver: stall pattern that changes mode now and then, plus one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_mode = 0;
			mode_left  = 0;
			hold_left  = 0;
		end else if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && results_checked >= 400) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			out_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(16, 96);
			end
			mode_left--;
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		ncpu_res_t want;
		ncpu_res_t got;

		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			results_checked++;
			if (expected_states.size() == 0) begin
				report_mismatch("result with no instruction pending", int'(got.pc_out), 0);
			end else begin
				want = expected_states.pop_front();
				if (got.acc_out !== want.acc_out)
					report_mismatch("acc_out", int'(got.acc_out), int'(want.acc_out));
				if (got.carry_out !== want.carry_out)
					report_mismatch("carry_out", int'(got.carry_out),
						int'(want.carry_out));
				if (got.pc_out !== want.pc_out)
					report_mismatch("pc_out", int'(got.pc_out), int'(want.pc_out));
				if (got.instr_cycles !== want.instr_cycles)
					report_mismatch("instr_cycles", int'(got.instr_cycles),
						int'(want.instr_cycles));
				if (got.src_valid !== want.src_valid)
					report_mismatch("src_valid", int'(got.src_valid),
						int'(want.src_valid));
				if (got.src_address !== want.src_address)
					report_mismatch("src_address", int'(got.src_address),
						int'(want.src_address));
				if (got.pair_zero_value !== want.pair_zero_value)
					report_mismatch("pair_zero_value", int'(got.pair_zero_value),
						int'(want.pair_zero_value));
			end
		end
	end

	initial begin
		int         kind;
		int         n;
		logic [3:0] nib;
		logic [3:0] rnd_grp;
		logic [2:0] pr;

		arst_n       = 1'b0;
		for (int i = 0; i < 16; i++)
			gpr_file[i] = 4'd0;
		for (int i = 0; i < STACK_LEVELS; i++)
			ret_stack[i] = 12'd0;
		cpu_acc   = 4'd0;
		cpu_carry = 1'b0;
		cpu_pc    = 12'd0;
		ret_sp    = 0;

		// Directed: every implemented operation, field extremes and the corner cases
		queue_instr({GRP_NOP, 4'h0}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_LDM, 4'hF}, 8'hFF, 1'b1, 8'hFF);
		queue_instr({GRP_XCH, 4'h0}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_FIM_SRC, 4'h2}, 8'hFF, 1'b0, 8'h00);
		queue_instr({GRP_ADD, 4'h2}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ADD, 4'h3}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_SUB, 4'h3}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_LD, 4'h0}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_STC}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_RAL}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_RAR}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_CMC}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_IAC}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_DAC}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_CMA}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_CLC}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ACC, ACC_CLB}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_JCN, JCN_ACC_ZERO}, 8'hAA, 1'b0, 8'h00);
		queue_instr({GRP_JCN, JCN_INVERT | JCN_TEST_LOW}, 8'h55, 1'b1, 8'h00);
		queue_instr({GRP_INC, 4'hF}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_ISZ, 4'hF}, 8'h33, 1'b0, 8'h00);
		// FIN loading pair 0 with its ROM byte, then send and jump through pairs
		queue_instr({GRP_FIN_JIN, 4'h0}, 8'h00, 1'b0, 8'hA5);
		queue_instr({GRP_FIM_SRC, 4'h1}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_FIN_JIN, 4'h3}, 8'h00, 1'b0, 8'h00);
		// Four calls overflow the stack, four returns underflow it
		queue_instr({GRP_JMS, 4'hF}, 8'hFF, 1'b0, 8'h00);
		queue_instr({GRP_JMS, 4'h0}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_JMS, 4'hA}, 8'h5A, 1'b0, 8'h00);
		queue_instr({GRP_JMS, 4'h5}, 8'hA5, 1'b0, 8'h00);
		queue_instr({GRP_BBL, 4'h0}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_BBL, 4'h5}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_BBL, 4'hA}, 8'h00, 1'b0, 8'h00);
		queue_instr({GRP_BBL, 4'hF}, 8'h00, 1'b0, 8'h00);
		// Wrap the PC past the top of memory
		queue_instr({GRP_JUN, 4'hF}, 8'hFF, 1'b0, 8'h00);
		queue_instr({GRP_FIM_SRC, 4'h0}, 8'h00, 1'b0, 8'h00);
		// Opcodes that decode as no-ops
		queue_instr({GRP_IO, 4'h0}, 8'hFF, 1'b1, 8'hFF);
		queue_instr({GRP_ACC, ACC_DAA}, 8'hFF, 1'b1, 8'hFF);
		queue_instr({GRP_ACC, 4'hF}, 8'hFF, 1'b1, 8'hFF);

		n = pending_instrs.size() + RANDOM_ITEMS;
		while (pending_instrs.size() < n) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1: queue_instr(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				2: begin
					// call, a few body instructions, return
					queue_op(GRP_JMS, 4'($urandom_range(0, 15)));
					repeat ($urandom_range(0, 3)) begin
						rnd_grp = 4'($urandom_range(0, 15));
						queue_op(grp_t'(rnd_grp), 4'($urandom_range(0, 15)));
					end
					queue_op(GRP_BBL, 4'($urandom_range(0, 15)));
				end
				3: begin
					// counted loop on one register
					nib = 4'($urandom_range(0, 15));
					repeat ($urandom_range(1, 16))
						queue_op(GRP_ISZ, nib);
				end
				4: begin
					// load a pair, then use it
					pr = 3'($urandom_range(0, 7));
					queue_op(GRP_FIM_SRC, {pr, 1'b0});
					case ($urandom_range(0, 2))
						0: queue_op(GRP_FIM_SRC, {pr, 1'b1});
						1: queue_op(GRP_FIN_JIN, {pr, 1'b1});
						default: queue_op(GRP_FIN_JIN, {pr, 1'b0});
					endcase
				end
				default: begin
					rnd_grp = 4'($urandom_range(0, 15));
					queue_op(grp_t'(rnd_grp), 4'($urandom_range(0, 15)));
				end
			endcase
		end
		total_items = pending_instrs.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (results_checked < total_items)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		n = 0;
		for (int i = 0; i < 16; i++)
			if (group_hits[i] != 0)
				n++;
		$display("Executed %0d instructions, checked %0d results, %0d mismatches.",
			items_accepted, results_checked, mismatch_count);
		$display("Opcode groups hit: %0d of 16; calls %0d, returns %0d, ISZ %0d.",
			n, group_hits[GRP_JMS], group_hits[GRP_BBL], group_hits[GRP_ISZ]);
		if (mismatch_count == 0 && expected_states.size() == 0 &&
			items_accepted == total_items) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
